FILE: design/clil_pkg.sv
// Shared types, field widths and codes for the circular list block.
// No dependencies; clil_alloc and circular_list_insert_delete import this package.
package clil_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VALUE_W      = 32;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 3;

  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUMP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IS_FIRST  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IS_LAST   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value_out;
    logic                      last;
  } out_item_t;

  // slot allocator commands
  typedef struct packed {
    logic take;  // claim the lowest free slot
    logic give;  // return give_slot to the free pool
  } alloc_ctl_t;

endpackage

FILE: design/clil_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/clil_alloc.sv
// Free-slot map and lowest-free-slot picker for the list store.
// Depends on clil_pkg.
module clil_alloc #(
  parameter int CAPACITY = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  clil_pkg::alloc_ctl_t        ctl,
  input  logic [$clog2(CAPACITY)-1:0] give_slot,
  output logic [$clog2(CAPACITY)-1:0] pick,
  output logic [CAPACITY-1:0]         free_map
);
  import clil_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic [CAPACITY-1:0] free_map_r;
  logic [CAPACITY-1:0] free_map_nxt;
  logic [AW-1:0]       pick_c;

  // lowest set bit wins
  always_comb begin
    pick_c = '0;
    for (int s = CAPACITY - 1; s >= 0; s--) begin
      if (free_map_r[s]) begin
        pick_c = AW'(s);
      end
    end
  end

  always_comb begin
    free_map_nxt = free_map_r;
    if (ctl.take) begin
      free_map_nxt[pick_c] = 1'b0;
    end
    if (ctl.give) begin
      free_map_nxt[give_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_map_r <= '1;
    end else begin
      free_map_r <= free_map_nxt;
    end
  end

  assign pick     = pick_c;
  assign free_map = free_map_r;

endmodule

FILE: design/circular_list_insert_delete.sv
// Circular singly linked list: add at head, delete first match unless it is the head or tail of a longer list, dump.
// A full add, or a delete or dump of an empty list, gives its result strobe in the cycle after
// acceptance; any other add answers from S_ADD, and delete and dump answer from the walk.
// Dump emits one item per cycle; the walk reads one linked entry per cycle from the RAMs.
// One item at a time: busy holds off start until the add or walk ends; a full add or an empty
// delete or dump leaves busy low.
// Reset (synchronous, rst_n low): list empty, all slots free; RAM contents left undefined.
module circular_list_insert_delete #(
  parameter int CAPACITY = clil_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  clil_pkg::in_item_t  in_item,
  output logic                out_valid,
  output clil_pkg::out_item_t out_item
);
  import clil_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;  // second link write of an add
  localparam logic [1:0] S_SRCH = 2'd2;  // delete search walk
  localparam logic [1:0] S_DUMP = 2'd3;  // dump walk

  // control state
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;

  // walk and payload registers
  logic [AW-1:0]             cur_r, cur_nxt;
  logic [AW-1:0]             prev_r, prev_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  // memory ports
  logic                      val_we;
  logic                      link_we;
  logic [AW-1:0]             val_waddr;
  logic [AW-1:0]             link_waddr;
  logic [AW-1:0]             link_wdata;
  logic [AW-1:0]             rd_addr;
  logic [VALUE_W-1:0]        val_rd;
  logic [AW-1:0]             link_rd;

  // allocator
  alloc_ctl_t          alloc_ctl;
  logic [AW-1:0]       give_slot;
  logic [AW-1:0]       pick;
  logic [CAPACITY-1:0] free_map;

  logic accept;
  logic walk_end;
  logic hit;

  assign accept   = start && !busy;
  assign walk_end = (idx_r + CW'(1)) == count_r;
  assign hit      = $signed(val_rd) == val_r;

  clil_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_r),
    .raddr (rd_addr),
    .rdata (val_rd)
  );

  clil_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  clil_alloc #(.CAPACITY(CAPACITY)) u_alloc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (alloc_ctl),
    .give_slot (give_slot),
    .pick      (pick),
    .free_map  (free_map)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    val_we        = 1'b0;
    link_we       = 1'b0;
    val_waddr     = pick;
    link_waddr    = pick;
    link_wdata    = head_r;
    rd_addr       = link_rd;   // walks follow the link just read
    alloc_ctl     = '0;
    give_slot     = cur_r;

    case (state_r)
      S_IDLE: begin
        rd_addr = head_r;      // a walk always starts at the head
        if (accept) begin
          val_nxt = in_item.value;
          cur_nxt  = head_r;
          prev_nxt = head_r;
          idx_nxt  = '0;
          case (in_item.mode)
            MODE_ADD: begin
              if (count_r == CW'(CAPACITY)) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{ST_FULL, '0, 1'b1};
              end else begin
                // value write uses val_r, so it lands in S_ADD or next cycle
                link_we       = 1'b1;
                alloc_ctl.take = 1'b1;
                head_nxt      = pick;
                count_nxt     = count_r + CW'(1);
                cur_nxt       = pick;
                state_nxt     = S_ADD;
                if (count_r == '0) begin
                  link_wdata = pick;  // lone element links to itself
                  tail_nxt   = pick;
                end
              end
            end
            MODE_DEL, MODE_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{ST_EMPTY, '0, 1'b1};
              end else begin
                state_nxt = (in_item.mode == MODE_DEL) ? S_SRCH : S_DUMP;
              end
            end
            default: begin
              // unused mode: item dropped, no result
            end
          endcase
        end
      end

      S_ADD: begin
        // value goes to the new slot; tail is pointed at the new head
        val_we        = 1'b1;
        val_waddr     = cur_r;
        link_we       = (count_r != CW'(1));
        link_waddr    = tail_r;
        link_wdata    = head_r;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{ST_OK, '0, 1'b1};
        state_nxt     = S_IDLE;
      end

      S_SRCH: begin
        cur_nxt  = link_rd;
        prev_nxt = cur_r;
        idx_nxt  = idx_r + CW'(1);
        if (count_r == CW'(1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (hit) begin
            alloc_ctl.give = 1'b1;
            count_nxt      = '0;
            out_item_nxt   = '{ST_OK, '0, 1'b1};
          end else begin
            out_item_nxt   = '{ST_NOT_FOUND, '0, 1'b1};
          end
        end else if (hit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (cur_r == head_r) begin
            out_item_nxt = '{ST_IS_FIRST, '0, 1'b1};
          end else if (cur_r == tail_r) begin
            out_item_nxt = '{ST_IS_LAST, '0, 1'b1};
          end else begin
            // middle match: predecessor skips over it
            link_we        = 1'b1;
            link_waddr     = prev_r;
            link_wdata     = link_rd;
            alloc_ctl.give = 1'b1;
            count_nxt      = count_r - CW'(1);
            out_item_nxt   = '{ST_OK, '0, 1'b1};
          end
        end else if (walk_end) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{ST_NOT_FOUND, '0, 1'b1};
          state_nxt     = S_IDLE;
        end
      end

      S_DUMP: begin
        idx_nxt       = idx_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{ST_OK, $signed(val_rd), walk_end};
        if (walk_end) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // live elements plus free slots always cover the store exactly
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(free_map) + int'(count_r)) == CAPACITY)
    else $error("free map and element count disagree");

  // only dump elements come without last, and they are always status ok
  a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> out_item.status == ST_OK)
    else $error("non-final result with bad status");

  // a dump streams with no gaps until its last element
  a_dump_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid)
    else $error("dump stream broken");

  // a result strobe must not stem from the idle state while busy; busy rules out the idle state, so this always holds
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !(out_valid && $past(state_r) == S_IDLE))
    else $error("result strobe without finishing walk");

endmodule
